FILE: src/fcpid_pkg.sv
package fcpid_pkg;

    // Field widths fixed by the stream format.
    localparam int POS_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int ERR_W   = 17;
    localparam int INT_W   = 18;
    localparam int DIFF_W  = 18;
    localparam int CLAMP_W = 8;
    localparam int DRV_W   = 8;
    localparam int PROD_W  = 34;
    localparam int SUM_W   = 36;
    localparam int FRAC_W  = 8;
    localparam int RAW_W   = SUM_W - FRAC_W;
    localparam int CFG_W   = 2;
    localparam int CH_W    = 2;

    // Symmetric limits for the stored integral as it is read back, and for the drive.
    localparam logic signed [CLAMP_W-1:0] INT_LIMIT = 8'sd100;
    localparam logic signed [DRV_W-1:0]   DRV_LIMIT = 8'sd100;

    // Configuration register indexes.
    typedef enum logic [CFG_W-1:0] {
        CFG_KP = 2'd0,
        CFG_KI = 2'd1,
        CFG_KD = 2'd2
    } t_cfg_index;

    // Per-channel loop state held in the state memory.
    typedef struct packed {
        logic [INT_W-1:0] integral;
        logic [ERR_W-1:0] prev_error;
        logic [POS_W-1:0] prev_target;
    } t_chan_state;

endpackage

FILE: src/fcpid_state_mem.sv
module fcpid_state_mem #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output fcpid_pkg::t_chan_state    o_rd_data,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  fcpid_pkg::t_chan_state    i_wr_data
);

    fcpid_pkg::t_chan_state r_mem [DEPTH];
    fcpid_pkg::t_chan_state r_rd_data;
    logic [DEPTH-1:0]       r_vld;
    logic                   r_rd_vld;

    // Entry storage and registered read; a read at the write address sees the old entry.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Written flags: an entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: src/four_channel_position_pid.sv
// Channel      Direction  Handshake                         Payload
// s_axis       in         i_s_axis_tvalid / o_s_axis_tready tuser: channel; tdata: target, measured
// m_axis       out        o_m_axis_tvalid / i_m_axis_tready tdata: drive
// cfg          in         i_cfg_valid / o_cfg_ready         i_cfg_index, i_cfg_data (gains)
//
// One request is accepted per cycle unless stalled; the drive is registered stage by stage.
// The state memory is read on acceptance and written back when stage 1 moves on, and
// a back-to-back request on the same channel takes the written value by forwarding.
// Reset clears the gains, the pipeline and the per-channel written flags at once.
// A stalled output fills the pipeline bubbles first; the input stalls only when it is full.
module four_channel_position_pid #(
    parameter int CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] channel
    input  logic [31:0] i_s_axis_tdata,   // [15:0] target_position, [31:16] measured_position
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] drive
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RW = ((AW > fcpid_pkg::CH_W) ? AW : fcpid_pkg::CH_W) + 1;

    localparam int POS_W   = fcpid_pkg::POS_W;
    localparam int ERR_W   = fcpid_pkg::ERR_W;
    localparam int INT_W   = fcpid_pkg::INT_W;
    localparam int DIFF_W  = fcpid_pkg::DIFF_W;
    localparam int CLAMP_W = fcpid_pkg::CLAMP_W;
    localparam int DRV_W   = fcpid_pkg::DRV_W;
    localparam int PROD_W  = fcpid_pkg::PROD_W;
    localparam int SUM_W   = fcpid_pkg::SUM_W;
    localparam int FRAC_W  = fcpid_pkg::FRAC_W;
    localparam int RAW_W   = fcpid_pkg::RAW_W;
    localparam int GAIN_W  = fcpid_pkg::GAIN_W;

    // Gains
    logic [GAIN_W-1:0] r_kp, r_ki, r_kd;

    // Pipeline valids and handshakes
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_o_vld;
    logic w_o_adv, w_s4_adv, w_s3_adv, w_s2_adv, w_s1_adv, w_accept;

    // Stage 0
    logic [RW-1:0]    n_ch_mod;
    logic [AW-1:0]    w_rd_addr;
    logic [POS_W-1:0] w_tgt, w_meas;
    logic [ERR_W-1:0] w_err;

    // Stage 1
    logic [AW-1:0]          r_s1_ch;
    logic [POS_W-1:0]       r_s1_tgt;
    logic [ERR_W-1:0]       r_s1_err;
    logic                   r_fwd_hit;
    fcpid_pkg::t_chan_state r_fwd_data;
    fcpid_pkg::t_chan_state w_rd_data, w_cur, n_state;
    logic                   w_changed;
    logic [CLAMP_W-1:0]     w_int_clamp;
    logic [ERR_W-1:0]       w_prev_err;
    logic [INT_W-1:0]       n_integ;
    logic [DIFF_W-1:0]      n_diff;
    logic                   w_wr_en;

    // Stage 2
    logic [ERR_W-1:0]  r_s2_err;
    logic [INT_W-1:0]  r_s2_integ;
    logic [DIFF_W-1:0] r_s2_diff;
    logic              r_s2_one;

    // Stage 3
    logic signed [PROD_W-1:0] r_s3_pp, r_s3_pi, r_s3_pd;
    logic                     r_s3_one;

    // Stage 4
    logic signed [SUM_W-1:0] r_s4_sum;
    logic                    r_s4_one;
    logic signed [SUM_W-1:0] w_sum_adj;
    logic signed [RAW_W-1:0] w_raw;
    logic signed [DRV_W-1:0] w_clamped;
    logic [DRV_W-1:0]        n_drive;

    // Output
    logic [DRV_W-1:0] r_o_drive;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= '0;
            r_ki <= '0;
            r_kd <= '0;
        end else if (i_cfg_valid) begin
            case (fcpid_pkg::t_cfg_index'(i_cfg_index))
                fcpid_pkg::CFG_KP: r_kp <= i_cfg_data;
                fcpid_pkg::CFG_KI: r_ki <= i_cfg_data;
                fcpid_pkg::CFG_KD: r_kd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Each stage moves on when it is empty or the stage after it moves on.
    assign w_o_adv  = !r_o_vld  || i_m_axis_tready;
    assign w_s4_adv = !r_s4_vld || w_o_adv;
    assign w_s3_adv = !r_s3_vld || w_s4_adv;
    assign w_s2_adv = !r_s2_vld || w_s3_adv;
    assign w_s1_adv = !r_s1_vld || w_s2_adv;
    assign w_accept = i_s_axis_tvalid && w_s1_adv;
    assign o_s_axis_tready = w_s1_adv;

    // Stage 0: wrap the channel number and form the error.
    always_comb begin
        n_ch_mod = RW'(i_s_axis_tuser);
        for (int k = 0; k < 3; k++) begin
            if (n_ch_mod >= RW'(CHANNELS)) begin
                n_ch_mod = n_ch_mod - RW'(CHANNELS);
            end
        end
    end

    assign w_rd_addr = n_ch_mod[AW-1:0];
    assign w_tgt     = i_s_axis_tdata[POS_W-1:0];
    assign w_meas    = i_s_axis_tdata[2*POS_W-1:POS_W];
    assign w_err     = {w_meas[POS_W-1], w_meas} - {w_tgt[POS_W-1], w_tgt};

    fcpid_state_mem #(
        .DEPTH (CHANNELS),
        .AW    (AW)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_ch),
        .i_wr_data (n_state)
    );

    // Stage 1: pick the freshest state, apply target change and integral clamp.
    assign w_cur     = r_fwd_hit ? r_fwd_data : w_rd_data;
    assign w_changed = (r_s1_tgt != w_cur.prev_target);

    always_comb begin
        if ($signed(w_cur.integral) > $signed(INT_W'(fcpid_pkg::INT_LIMIT))) begin
            w_int_clamp = fcpid_pkg::INT_LIMIT;
        end else if ($signed(w_cur.integral) < -$signed(INT_W'(fcpid_pkg::INT_LIMIT))) begin
            w_int_clamp = -fcpid_pkg::INT_LIMIT;
        end else begin
            w_int_clamp = w_cur.integral[CLAMP_W-1:0];
        end
        if (w_changed) begin
            w_int_clamp = '0;
        end
    end

    assign w_prev_err = w_changed ? '0 : w_cur.prev_error;
    assign n_integ    = {{(INT_W-CLAMP_W){w_int_clamp[CLAMP_W-1]}}, w_int_clamp}
                      + {{(INT_W-ERR_W){r_s1_err[ERR_W-1]}}, r_s1_err};
    assign n_diff     = {{(DIFF_W-ERR_W){r_s1_err[ERR_W-1]}}, r_s1_err}
                      - {{(DIFF_W-ERR_W){w_prev_err[ERR_W-1]}}, w_prev_err};

    assign n_state.integral    = n_integ;
    assign n_state.prev_error  = r_s1_err;
    assign n_state.prev_target = r_s1_tgt;
    assign w_wr_en             = r_s1_vld && w_s2_adv;

    // Stage 4: truncate toward zero, clamp and negate; an error of plus or minus one gives zero.
    assign w_sum_adj = r_s4_sum[SUM_W-1] ? (r_s4_sum + SUM_W'(2**FRAC_W - 1)) : r_s4_sum;
    assign w_raw     = w_sum_adj[SUM_W-1:FRAC_W];

    always_comb begin
        if (w_raw > RAW_W'(fcpid_pkg::DRV_LIMIT)) begin
            w_clamped = fcpid_pkg::DRV_LIMIT;
        end else if (w_raw < -RAW_W'(fcpid_pkg::DRV_LIMIT)) begin
            w_clamped = -fcpid_pkg::DRV_LIMIT;
        end else begin
            w_clamped = w_raw[DRV_W-1:0];
        end
    end

    assign n_drive = r_s4_one ? '0 : DRV_W'(-w_clamped);

    // Pipeline valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (w_s1_adv) r_s1_vld <= i_s_axis_tvalid;
            if (w_s2_adv) r_s2_vld <= r_s1_vld;
            if (w_s3_adv) r_s3_vld <= r_s2_vld;
            if (w_s4_adv) r_s4_vld <= r_s3_vld;
            if (w_o_adv)  r_o_vld  <= r_s4_vld;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_ch    <= w_rd_addr;
            r_s1_tgt   <= w_tgt;
            r_s1_err   <= w_err;
            r_fwd_hit  <= w_wr_en && (r_s1_ch == w_rd_addr);
            r_fwd_data <= n_state;
        end
        if (w_s2_adv) begin
            r_s2_err   <= r_s1_err;
            r_s2_integ <= n_integ;
            r_s2_diff  <= n_diff;
            r_s2_one   <= (r_s1_err == ERR_W'(1)) || (r_s1_err == {ERR_W{1'b1}});
        end
        if (w_s3_adv) begin
            r_s3_pp  <= $signed(r_kp) * $signed(r_s2_err);
            r_s3_pi  <= $signed(r_ki) * $signed(r_s2_integ);
            r_s3_pd  <= $signed(r_kd) * $signed(r_s2_diff);
            r_s3_one <= r_s2_one;
        end
        if (w_s4_adv) begin
            r_s4_sum <= SUM_W'(r_s3_pp) + SUM_W'(r_s3_pi) + SUM_W'(r_s3_pd);
            r_s4_one <= r_s3_one;
        end
        if (w_o_adv) begin
            r_o_drive <= n_drive;
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = r_o_drive;

endmodule

FILE: src/fcpid_checker.sv
module fcpid_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata
);

    // A result that waits keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("drive changed while stalled");

    // The drive never leaves its clamp range.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata) <= 8'sd100)
                         && ($signed(o_m_axis_tdata) >= -8'sd100))
        else $error("drive out of range");

    // The input stalls only behind a stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled without output back-pressure");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind four_channel_position_pid fcpid_checker u_fcpid_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: tb/tb_four_channel_position_pid.sv
`timescale 1ns / 100ps

module tb_four_channel_position_pid;

    localparam int CFG_W  = fcpid_pkg::CFG_W;
    localparam int CH_W   = fcpid_pkg::CH_W;
    localparam int POS_W  = fcpid_pkg::POS_W;
    localparam int DRV_W  = fcpid_pkg::DRV_W;
    localparam int GAIN_W = fcpid_pkg::GAIN_W;
    localparam int INT_W  = fcpid_pkg::INT_W;
    localparam int ERR_W  = fcpid_pkg::ERR_W;

    localparam int NUM_CH         = 4;
    localparam int PHASES         = 8;
    localparam int PHASE_SAMPLES  = 235;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 4000;

    // The register index that maps to no gain; writes to it must be dropped.
    localparam logic [CFG_W-1:0] CFG_NONE = 2'd3;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [CH_W-1:0]     i_s_axis_tuser = '0;
    logic [2*POS_W-1:0]  i_s_axis_tdata = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [DRV_W-1:0]    o_m_axis_tdata;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_index = '0;
    logic [GAIN_W-1:0]   i_cfg_data = '0;

    four_channel_position_pid #(
        .CHANNELS(NUM_CH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Loop state and gains as the block should hold them.
    logic signed [GAIN_W-1:0] kp_q = '0;
    logic signed [GAIN_W-1:0] ki_q = '0;
    logic signed [GAIN_W-1:0] kd_q = '0;
    logic signed [INT_W-1:0]  integ_q    [NUM_CH] = '{default: '0};
    logic signed [ERR_W-1:0]  prev_err_q [NUM_CH] = '{default: '0};
    logic signed [POS_W-1:0]  prev_tgt_q [NUM_CH] = '{default: '0};

    logic signed [DRV_W-1:0] pending_drives [$];
    int unsigned drives_checked = 0;
    int unsigned fault_count = 0;
    int unsigned quiet_cycles = 0;

    // Directed script: a gain write or a sample, with the drive typed in where it is obvious.
    typedef enum logic {ROW_GAIN, ROW_SAMPLE} t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [1:0]              sel;     // channel or register index
        logic [POS_W-1:0]        a;       // target or gain value
        logic [POS_W-1:0]        b;       // measured position
        logic                    typed;
        logic signed [DRV_W-1:0] drive;
    } t_script_row;

    localparam int SCRIPT_LEN = 29;

    t_script_row script [SCRIPT_LEN] = '{
        // Gains are zero after reset, so any sample drives zero.
        '{ROW_SAMPLE, 2'd0, 16'h0000, 16'h0000, 1'b1, 8'sd0},
        '{ROW_SAMPLE, 2'd3, 16'h8000, 16'h7FFF, 1'b1, 8'sd0},
        // Unit proportional gain: drive is the negated error, clamped; unit errors give zero.
        '{ROW_GAIN,   fcpid_pkg::CFG_KP, 16'h0100, 16'h0000, 1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd0, 16'h0000, 16'd50,   1'b1, -8'sd50},
        '{ROW_SAMPLE, 2'd1, 16'h0000, 16'h0001, 1'b1, 8'sd0},
        '{ROW_SAMPLE, 2'd1, 16'h0000, 16'hFFFF, 1'b1, 8'sd0},
        '{ROW_SAMPLE, 2'd2, 16'h0000, 16'h7FFF, 1'b1, -8'sd100},
        '{ROW_SAMPLE, 2'd2, 16'h0000, 16'h8000, 1'b1, 8'sd100},
        '{ROW_SAMPLE, 2'd3, 16'h8000, 16'h7FFF, 1'b1, -8'sd100},
        '{ROW_SAMPLE, 2'd3, 16'h7FFF, 16'h8000, 1'b1, 8'sd100},
        // Extreme gains; target changes clear the loop state.
        '{ROW_GAIN,   fcpid_pkg::CFG_KI, 16'h0100, 16'h0000, 1'b0, 8'sd0},
        '{ROW_GAIN,   fcpid_pkg::CFG_KD, 16'h8000, 16'h0000, 1'b0, 8'sd0},
        '{ROW_GAIN,   fcpid_pkg::CFG_KP, 16'h7FFF, 16'h0000, 1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd0, 16'd100,  16'h0000, 1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd0, 16'd100,  16'h0000, 1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd0, 16'd100,  16'h0001, 1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd0, 16'd100,  16'd99,   1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd0, 16'd100,  16'd100,  1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd0, 16'd5,    16'd5,    1'b0, 8'sd0},
        // A write to the unused index must leave every gain alone.
        '{ROW_GAIN,   CFG_NONE, 16'hFFFF, 16'h0000, 1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd1, 16'h0000, 16'h8000, 1'b0, 8'sd0},
        '{ROW_GAIN,   fcpid_pkg::CFG_KI, 16'h8000, 16'h0000, 1'b0, 8'sd0},
        '{ROW_GAIN,   fcpid_pkg::CFG_KD, 16'h7FFF, 16'h0000, 1'b0, 8'sd0},
        '{ROW_GAIN,   fcpid_pkg::CFG_KP, 16'h8000, 16'h0000, 1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd1, 16'h0000, 16'h8000, 1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd1, 16'h0000, 16'h8000, 1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd2, 16'hFFFF, 16'hFFFF, 1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd2, 16'hFFFF, 16'h0000, 1'b0, 8'sd0},
        '{ROW_SAMPLE, 2'd3, 16'h7FFF, 16'h7FFF, 1'b0, 8'sd0}
    };

    // Advance one channel of the loop by one sample and return the drive it gives.
    function automatic logic signed [DRV_W-1:0] next_drive(
        input logic [CH_W-1:0] ch,
        input logic signed [POS_W-1:0] tgt,
        input logic signed [POS_W-1:0] meas
    );
        logic signed [ERR_W-1:0] err;
        logic signed [INT_W-1:0] held;
        logic signed [INT_W-1:0] integ;
        longint acc;
        longint raw;

        if (tgt != prev_tgt_q[ch]) begin
            integ_q[ch] = '0;
            prev_err_q[ch] = '0;
        end
        err = $signed({meas[POS_W-1], meas}) - $signed({tgt[POS_W-1], tgt});
        held = integ_q[ch];
        if (held > 100) begin
            held = 100;
        end else if (held < -100) begin
            held = -100;
        end
        integ = held + err;
        acc = longint'(kp_q) * longint'(err)
            + longint'(ki_q) * longint'(integ)
            + longint'(kd_q) * (longint'(err) - longint'(prev_err_q[ch]));
        raw = acc / 256;
        integ_q[ch] = integ;
        prev_err_q[ch] = err;
        prev_tgt_q[ch] = tgt;
        if (err == 1 || err == -1) begin
            raw = 0;
        end
        if (raw > 100) begin
            raw = 100;
        end else if (raw < -100) begin
            raw = -100;
        end
        return DRV_W'(-raw);
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Gain value: extremes, small everyday gains, or anything at all.
    function automatic logic [GAIN_W-1:0] pick_gain();
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 6) begin
            return 16'h7FFF;
        end else if (r < 12) begin
            return 16'h8000;
        end else if (r < 16) begin
            return 16'h0000;
        end else if (r < 70) begin
            return GAIN_W'($urandom_range(0, 2048) - 1024);
        end
        return GAIN_W'($urandom());
    endfunction

    // Offer one sample after an optional gap and record its drive once accepted.
    task automatic send_sample(
        input logic [CH_W-1:0] ch,
        input logic [POS_W-1:0] tgt,
        input logic [POS_W-1:0] meas,
        input int unsigned gap,
        input logic typed,
        input logic signed [DRV_W-1:0] typed_drive
    );
        logic signed [DRV_W-1:0] drive;

        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= ch;
        i_s_axis_tdata  <= {meas, tgt};
        do @(posedge i_clk); while (!o_s_axis_tready);
        drive = next_drive(ch, tgt, meas);
        pending_drives.push_back(typed ? typed_drive : drive);
        @(negedge i_clk);
    endtask

    // One gain register write request.
    task automatic write_gain(input logic [CFG_W-1:0] index, input logic [GAIN_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            fcpid_pkg::CFG_KP: kp_q = value;
            fcpid_pkg::CFG_KI: ki_q = value;
            fcpid_pkg::CFG_KD: kd_q = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drain every outstanding drive, then let the pipeline go quiet.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Compare every accepted drive with the oldest outstanding one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_drives.size() == 0) begin
                $error("drive: unexpected result %0d", $signed(o_m_axis_tdata));
                fault_count++;
            end else begin
                if ($signed(o_m_axis_tdata) !== pending_drives[0]) begin
                    $error("drive: expected %0d, got %0d", pending_drives[0],
                           $signed(o_m_axis_tdata));
                    fault_count++;
                end
                void'(pending_drives.pop_front());
            end
            drives_checked++;
        end
    end

    // End the run when no request moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_four_channel_position_pid failed");
                $finish;
            end
        end
    end

    // Output back-pressure: bursts of ready, random stalls, and a few long hold-offs
    // so the pipeline fills and the input stalls.
    initial begin : drain_control
        int unsigned hold_mark;
        int unsigned stall;

        hold_mark = 400;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (drives_checked >= hold_mark) begin
                hold_mark += 700;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge i_clk);
            stall = pick_gap();
            if (stall != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    // Reset, the directed script, then random phases with fresh gains.
    initial begin : stimulus
        logic [POS_W-1:0] aim [NUM_CH];
        logic [POS_W-1:0] tgt;
        logic [POS_W-1:0] meas;
        logic [CH_W-1:0]  ch;
        int               off;
        int unsigned      r;
        bit               calm;

        aim = '{default: '0};
        calm = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_GAIN) begin
                settle();
                write_gain(script[i].sel, script[i].a);
            end else begin
                send_sample(script[i].sel, script[i].a, script[i].b, 0,
                            script[i].typed, script[i].drive);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == 0) begin
                write_gain(fcpid_pkg::CFG_KP, 16'h7FFF);
                write_gain(fcpid_pkg::CFG_KI, 16'h8000);
                write_gain(fcpid_pkg::CFG_KD, 16'h7FFF);
            end else if (p == 1) begin
                write_gain(fcpid_pkg::CFG_KP, 16'h8000);
                write_gain(fcpid_pkg::CFG_KI, 16'h7FFF);
                write_gain(fcpid_pkg::CFG_KD, 16'h8000);
            end else begin
                write_gain(fcpid_pkg::CFG_KP, pick_gain());
                write_gain(fcpid_pkg::CFG_KI, pick_gain());
                write_gain(fcpid_pkg::CFG_KD, pick_gain());
            end
            if ($urandom_range(0, 2) == 0) begin
                write_gain(CFG_NONE, GAIN_W'($urandom()));
            end

            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                // Some stretches run with the sender never idle.
                if (n % 50 == 0) begin
                    calm = ($urandom_range(0, 3) == 0);
                end
                ch = CH_W'($urandom_range(0, NUM_CH - 1));
                r = $urandom_range(0, 99);
                // Channels mostly hold their target so the integral builds up.
                if (r < 8) begin
                    aim[ch] = POS_W'($urandom());
                end else if (r < 14) begin
                    aim[ch] = POS_W'($urandom_range(0, 400) - 200);
                end
                if (r >= 94) begin
                    meas = POS_W'($urandom());
                end else begin
                    if ($urandom_range(0, 9) < 3) begin
                        off = $urandom_range(0, 2) - 1;
                    end else begin
                        off = $urandom_range(0, 600) - 300;
                    end
                    meas = aim[ch] + POS_W'(off);
                end
                tgt = aim[ch];
                if ($urandom_range(0, 49) == 0) begin
                    tgt = POS_W'($urandom());
                end
                send_sample(ch, tgt, meas, calm ? 0 : pick_gap(), 1'b0, 8'sd0);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("tb_four_channel_position_pid passed");
        end else begin
            $display("tb_four_channel_position_pid failed");
        end
        $finish;
    end

endmodule

FILE: files.f
src/fcpid_pkg.sv
src/fcpid_state_mem.sv
src/four_channel_position_pid.sv
src/fcpid_checker.sv
tb/tb_four_channel_position_pid.sv
